>>> rtl/ewhs_pkg.sv
// Package with the edge record and sizing constants for the edge weight sorter.
`default_nettype none

package ewhs_pkg;

    localparam int MAX_EDGES = 64;
    localparam int CNT_W     = $clog2(MAX_EDGES + 1);
    localparam int VERTEX_W  = 10;
    localparam int WEIGHT_W  = 16;
    localparam int EDGE_W    = 2 * VERTEX_W + WEIGHT_W;
    localparam int TDATA_W   = ((EDGE_W + 7) / 8) * 8;

    typedef struct packed {
        logic                       valid;
        logic        [VERTEX_W-1:0] from_vertex;
        logic        [VERTEX_W-1:0] to_vertex;
        logic signed [WEIGHT_W-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    localparam edge_t EMPTY_EDGE = '0;

endpackage

`default_nettype wire

>>> rtl/edge_weight_heap_sorter.sv
// The first sorted edge is offered in the cycle after the beat marked last.
// Loading takes one edge per cycle; each edge drops into its sorted place while the chain has room.
// Draining gives one edge per cycle while the output is ready; no input is taken meanwhile.
// Reset empties every cell and clears the edge count and the drop flag at once.
`default_nettype none

module edge_weight_heap_sorter
    import ewhs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // from_vertex, to_vertex, weight, zero fill
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // out_from_vertex, out_to_vertex, out_weight, zero fill
    output logic                    m_tlast,
    output logic                    m_tuser    // dropped
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             drain_reg, drain_next;
    logic             overflow_reg, overflow_next;

    logic       in_beat, out_beat, room;
    cell_ctrl_t ctrl;
    edge_t      new_edge;
    edge_t      cells [MAX_EDGES];
    logic       keeps [MAX_EDGES];

    assign s_tready = !drain_reg;
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign room     = (count_reg != CNT_W'(MAX_EDGES));

    assign ctrl.insert = in_beat && room;
    assign ctrl.pop    = out_beat;

    assign new_edge.valid       = 1'b1;
    assign new_edge.from_vertex = s_tdata[VERTEX_W-1:0];
    assign new_edge.to_vertex   = s_tdata[2*VERTEX_W-1:VERTEX_W];
    assign new_edge.weight      = s_tdata[EDGE_W-1:2*VERTEX_W];

    for (genvar i = 0; i < MAX_EDGES; i++)
    begin : g_cell
        edge_t prev_e;
        edge_t next_e;
        logic  prev_k;

        if (i == 0)
        begin : g_head
            assign prev_e = EMPTY_EDGE;
            assign prev_k = 1'b1;
        end
        else
        begin : g_body
            assign prev_e = cells[i-1];
            assign prev_k = keeps[i-1];
        end

        if (i == MAX_EDGES - 1)
        begin : g_tail
            assign next_e = EMPTY_EDGE;
        end
        else
        begin : g_link
            assign next_e = cells[i+1];
        end

        ewhs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_edge  (new_edge),
            .prev_edge (prev_e),
            .prev_keep (prev_k),
            .next_edge (next_e),
            .edge_q    (cells[i]),
            .keep      (keeps[i])
        );
    end

    always_comb
    begin
        count_next    = count_reg;
        drain_next    = drain_reg;
        overflow_next = overflow_reg;
        if (in_beat)
        begin
            if (room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
            if (s_tlast)
            begin
                drain_next = 1'b1;
            end
        end
        if (out_beat)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                drain_next    = 1'b0;
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            drain_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            drain_reg    <= drain_next;
            overflow_reg <= overflow_next;
        end
    end

    assign m_tvalid = drain_reg;
    assign m_tlast  = (count_reg == CNT_W'(1));
    assign m_tuser  = overflow_reg;
    assign m_tdata  = {{(TDATA_W - EDGE_W){1'b0}}, cells[0].weight,
                       cells[0].to_vertex, cells[0].from_vertex};

    // The drain phase always has at least one edge left to give.
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (count_reg != '0))
        else $error("drain with empty chain");

    // The head cell holds a real edge whenever a beat is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cells[0].valid)
        else $error("output offered from an empty head cell");

    // The beat marked last opens the drain in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tlast) |=> m_tvalid)
        else $error("drain did not start after the last beat");

    // A taken beat that is not the final one leaves more beats to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !m_tlast) |=> (m_tvalid && cells[0].valid))
        else $error("drain ended before the final beat");

endmodule

`default_nettype wire

>>> rtl/ewhs_cell.sv
// One cell of the sorted chain: holds a single edge and moves it toward either neighbor.
`default_nettype none

module ewhs_cell
    import ewhs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire edge_t      new_edge,
    input  wire edge_t      prev_edge,
    input  wire logic       prev_keep,
    input  wire edge_t      next_edge,
    output edge_t           edge_q,
    output logic            keep
);

    edge_t edge_reg;
    edge_t edge_next;

    // An edge stays put when it is at least as heavy as the newcomer, which keeps
    // equal weights in arrival order.
    assign keep = edge_reg.valid && (edge_reg.weight >= new_edge.weight);

    always_comb
    begin
        edge_next = edge_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                edge_next = prev_keep ? new_edge : prev_edge;
            end
        end
        else if (ctrl.pop)
        begin
            edge_next = next_edge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg <= EMPTY_EDGE;
        end
        else
        begin
            edge_reg <= edge_next;
        end
    end

    assign edge_q = edge_reg;

endmodule

`default_nettype wire
